@@ src/rndi_pkg.sv @@
// ----------------------------------------------------------------------------
// rndi_pkg
// Shared types and constants of the normalized difference index pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rndi_pkg;

  // Result index format: signed, 16 bits
  localparam int INDEX_W = 16;

  // Quotient bits resolved per ratio; one bit beyond the rounding position
  // is enough to tell every saturated magnitude apart
  localparam int QUOT_BITS = 18;

  // Register stages in one divider: magnitude, range check, one per
  // quotient bit, round and saturate
  localparam int DIV_STAGES = QUOT_BITS + 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_B3   = 3'd0,
    REG_OFFSET_B3 = 3'd1,
    REG_GAIN_B4   = 3'd2,
    REG_OFFSET_B4 = 3'd3,
    REG_GAIN_B5   = 3'd4,
    REG_OFFSET_B5 = 3'd5,
    REG_GAIN_B7   = 3'd6,
    REG_OFFSET_B7 = 3'd7
  } reg_idx_t;

  // Per-item flags that travel alongside the quotient
  typedef struct packed {
    logic zero;
    logic neg;
    logic ovf;
  } rndi_flags_t;

endpackage

`default_nettype wire

@@ src/rndi_div.sv @@
// ----------------------------------------------------------------------------
// rndi_div
// Pipelined restoring divider for one normalized difference ratio: one
// quotient bit per stage, then round to nearest and saturate to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rndi_div #(
  parameter int D_W       = 50,
  parameter int FRAC_BITS = 13
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [D_W-1:0]             num,
  input  wire logic signed [D_W-1:0]             den,
  output      logic signed [rndi_pkg::INDEX_W-1:0] index,
  output      logic                              invalid
);

  localparam int QB  = rndi_pkg::QUOT_BITS;
  localparam int IW  = rndi_pkg::INDEX_W;
  localparam int CW  = D_W + FRAC_BITS + QB;
  localparam logic [QB-1:0] MAG_POS_MAX = QB'((1 << (IW - 1)) - 1);
  localparam logic [QB-1:0] MAG_NEG_MAX = QB'(1 << (IW - 1));

  // Magnitude stage
  logic [D_W-1:0]       n1;
  logic [D_W-1:0]       d1;
  rndi_pkg::rndi_flags_t f1;

  // Division stages
  logic [CW-1:0]        r_s [QB+1];
  logic [D_W-1:0]       d_s [QB+1];
  logic [QB-1:0]        q_s [QB+1];
  rndi_pkg::rndi_flags_t f_s [QB+1];

  logic [QB-1:0]        mag;

  // Take sign and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      n1      <= num[D_W-1] ? D_W'(-num) : D_W'(num);
      d1      <= den[D_W-1] ? D_W'(-den) : D_W'(den);
      f1.zero <= (den == '0);
      f1.neg  <= num[D_W-1] ^ den[D_W-1];
      f1.ovf  <= 1'b0;
    end
  end

  // Scale the dividend and check the quotient range
  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0]      <= CW'(n1) << (FRAC_BITS + 1);
      d_s[0]      <= d1;
      q_s[0]      <= '0;
      f_s[0].zero <= f1.zero;
      f_s[0].neg  <= f1.neg;
      f_s[0].ovf  <= (CW'(n1) << (FRAC_BITS + 1)) >= (CW'(d1) << QB);
    end
  end

  // Resolve one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(d_s[k]) << (QB - 1 - k);
    assign ge  = (r_s[k] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        r_s[k+1] <= ge ? (r_s[k] - dsh) : r_s[k];
        d_s[k+1] <= d_s[k];
        q_s[k+1] <= {q_s[k][QB-2:0], ge};
        f_s[k+1] <= f_s[k];
      end
    end
  end

  // Round half away from zero on the extra quotient bit
  assign mag = QB'(q_s[QB] >> 1) + QB'(q_s[QB][0]);

  // Apply sign, saturate, force zero on an empty denominator
  always_ff @(posedge clk) begin
    if (en) begin
      invalid <= f_s[QB].zero;
      if (f_s[QB].zero) begin
        index <= '0;
      end else if (f_s[QB].neg) begin
        if (f_s[QB].ovf || (mag >= MAG_NEG_MAX)) begin
          index <= {1'b1, {(IW-1){1'b0}}};
        end else begin
          index <= IW'(-mag);
        end
      end else begin
        if (f_s[QB].ovf || (mag > MAG_POS_MAX)) begin
          index <= {1'b0, {(IW-1){1'b1}}};
        end else begin
          index <= IW'(mag);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/reflectance_normalized_index_pixel.sv @@
// ----------------------------------------------------------------------------
// reflectance_normalized_index_pixel
// Rescales four band samples to reflectance and forms two normalized
// difference indices per pixel.
// ----------------------------------------------------------------------------
// One pixel enters per clock unless a finished item is held at the output,
// and the depth of the pipeline comes mostly from the divider, which
// resolves one quotient bit per pipeline stage. The whole pipeline advances
// together and holds only while a finished item sits at the output and the
// consumer stalls it; bubbles stay where they are meanwhile. Gains and offsets
// are signed Q1.30 and must be written only while the pipeline is empty.
// Indices are signed with INDEX_FRAC_BITS fraction bits, rounded to nearest
// and saturated; a zero denominator gives 0 with the matching invalid flag set.
`default_nettype none

module reflectance_normalized_index_pixel #(
  parameter int SAMPLE_BITS     = 16,
  parameter int INDEX_FRAC_BITS = 13
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // pixel in
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [15:0]        dn_band3,
  input  wire logic [15:0]        dn_band4,
  input  wire logic [15:0]        dn_band5,
  input  wire logic [15:0]        dn_band7,
  // indices out
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [15:0] vegetation_index,
  output      logic               vegetation_invalid,
  output      logic signed [15:0] tillage_index,
  output      logic               tillage_invalid
);

  localparam int P_W   = 33 + SAMPLE_BITS;
  localparam int R_W   = P_W + 1;
  localparam int D_W   = R_W + 1;
  localparam int DEPTH = 3 + rndi_pkg::DIV_STAGES;

  logic signed [31:0]        gain   [4];
  logic signed [31:0]        offset [4];
  logic [SAMPLE_BITS-1:0]    dn     [4];
  logic signed [P_W-1:0]     prod   [4];
  logic signed [R_W-1:0]     refl   [4];
  logic signed [D_W-1:0]     veg_num;
  logic signed [D_W-1:0]     veg_den;
  logic signed [D_W-1:0]     til_num;
  logic signed [D_W-1:0]     til_den;
  logic [DEPTH-1:0]          vld;
  logic                      en;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        gain[k]   <= '0;
        offset[k] <= '0;
      end
    end else if (cfg_write) begin
      case (rndi_pkg::reg_idx_t'(cfg_index))
        rndi_pkg::REG_GAIN_B3:   gain[0]   <= cfg_data;
        rndi_pkg::REG_OFFSET_B3: offset[0] <= cfg_data;
        rndi_pkg::REG_GAIN_B4:   gain[1]   <= cfg_data;
        rndi_pkg::REG_OFFSET_B4: offset[1] <= cfg_data;
        rndi_pkg::REG_GAIN_B5:   gain[2]   <= cfg_data;
        rndi_pkg::REG_OFFSET_B5: offset[2] <= cfg_data;
        rndi_pkg::REG_GAIN_B7:   gain[3]   <= cfg_data;
        rndi_pkg::REG_OFFSET_B7: offset[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance unless a finished item is held at the output
  assign en        = !vld[DEPTH-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  assign dn[0] = dn_band3[SAMPLE_BITS-1:0];
  assign dn[1] = dn_band4[SAMPLE_BITS-1:0];
  assign dn[2] = dn_band5[SAMPLE_BITS-1:0];
  assign dn[3] = dn_band7[SAMPLE_BITS-1:0];

  // Scale each sample by its gain
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= gain[k] * $signed({1'b0, dn[k]});
      end
    end
  end

  // Add the offsets
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        refl[k] <= R_W'(prod[k]) + R_W'(offset[k]);
      end
    end
  end

  // Form differences and sums
  always_ff @(posedge clk) begin
    if (en) begin
      veg_num <= D_W'(refl[1]) - D_W'(refl[0]);
      veg_den <= D_W'(refl[1]) + D_W'(refl[0]);
      til_num <= D_W'(refl[2]) - D_W'(refl[3]);
      til_den <= D_W'(refl[2]) + D_W'(refl[3]);
    end
  end

  rndi_div #(
    .D_W       (D_W),
    .FRAC_BITS (INDEX_FRAC_BITS)
  ) u_veg_div (
    .clk     (clk),
    .en      (en),
    .num     (veg_num),
    .den     (veg_den),
    .index   (vegetation_index),
    .invalid (vegetation_invalid)
  );

  rndi_div #(
    .D_W       (D_W),
    .FRAC_BITS (INDEX_FRAC_BITS)
  ) u_til_div (
    .clk     (clk),
    .en      (en),
    .num     (til_num),
    .den     (til_den),
    .index   (tillage_index),
    .invalid (tillage_invalid)
  );

  // An invalid ratio always reads as zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && vegetation_invalid |-> vegetation_index == '0)
    else $error("vegetation index not zero on invalid ratio");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && tillage_invalid |-> tillage_index == '0)
    else $error("tillage index not zero on invalid ratio");

  // A held output item keeps the pipeline frozen for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(vld))
    else $error("pipeline moved while output held");

  // Nothing leaves right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

`default_nettype wire

@@ tb/rndi_index_checker.sv @@
// ----------------------------------------------------------------------------
// rndi_index_checker
// Watches the pixel and index channels of the normalized difference index
// unit, predicts both indices of every accepted pixel and compares them in
// order with the indices that leave the block.
// ----------------------------------------------------------------------------
`default_nettype none

module rndi_index_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [15:0]        dn_band3,
  input  wire logic [15:0]        dn_band4,
  input  wire logic [15:0]        dn_band5,
  input  wire logic [15:0]        dn_band7,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [15:0] vegetation_index,
  input  wire logic               vegetation_invalid,
  input  wire logic signed [15:0] tillage_index,
  input  wire logic               tillage_invalid,
  output int                      fails,
  output int                      pending
);

  localparam int FRAC_BITS = 13;

  typedef struct packed {
    logic signed [15:0] veg;
    logic               veg_bad;
    logic signed [15:0] till;
    logic               till_bad;
  } indices_t;

  logic signed [31:0] gain_q [4];
  logic signed [31:0] offset_q [4];
  indices_t           expected_indices [$];

  // Reflectance of one band, exact: gain * dn + offset
  function automatic longint reflectance(logic signed [31:0] g, logic signed [31:0] o,
                                         logic [15:0] dn);
    return longint'(g) * longint'({48'b0, dn}) + longint'(o);
  endfunction

  // (a - b) / (a + b), rounded half away from zero, saturated to 16 bits
  function automatic logic [16:0] norm_diff(longint a, longint b);
    longint num;
    longint den;
    bit neg;
    longint unsigned n, d, q, rem;
    num = a - b;
    den = a + b;
    if (den == 0) return {16'sd0, 1'b1};
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    rem = n % d;
    if (q > 65536) q = 65536;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 1;
      end
    end
    rem = rem << 1;
    if (rem >= d) q = q + 1;
    if (neg) begin
      if (q >= 32768) return {16'h8000, 1'b0};
      return {16'(0 - q), 1'b0};
    end
    if (q > 32767) q = 32767;
    return {16'(q), 1'b0};
  endfunction

  // Predict on accepted pixels, compare on accepted indices
  always @(posedge clk) begin
    indices_t want;
    longint r3, r4, r5, r7;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        gain_q[i] = '0;
        offset_q[i] = '0;
      end
      expected_indices.delete();
      fails = 0;
    end else begin
      if (in_valid && !in_stall) begin
        r3 = reflectance(gain_q[0], offset_q[0], dn_band3);
        r4 = reflectance(gain_q[1], offset_q[1], dn_band4);
        r5 = reflectance(gain_q[2], offset_q[2], dn_band5);
        r7 = reflectance(gain_q[3], offset_q[3], dn_band7);
        {want.veg, want.veg_bad} = norm_diff(r4, r3);
        {want.till, want.till_bad} = norm_diff(r5, r7);
        // append at the tail
        expected_indices = {expected_indices, want};
      end
      if (out_valid && !out_stall) begin
        if (expected_indices.size() == 0) begin
          $error("unexpected index item: veg %0d till %0d", vegetation_index,
                 tillage_index);
          fails++;
        end else begin
          want = expected_indices.pop_front();
          if (vegetation_index !== want.veg) begin
            $error("vegetation_index: expected %0d, got %0d", want.veg, vegetation_index);
            fails++;
          end
          if (vegetation_invalid !== want.veg_bad) begin
            $error("vegetation_invalid: expected %0d, got %0d", want.veg_bad,
                   vegetation_invalid);
            fails++;
          end
          if (tillage_index !== want.till) begin
            $error("tillage_index: expected %0d, got %0d", want.till, tillage_index);
            fails++;
          end
          if (tillage_invalid !== want.till_bad) begin
            $error("tillage_invalid: expected %0d, got %0d", want.till_bad,
                   tillage_invalid);
            fails++;
          end
        end
      end
      // registers are paired gain/offset per band
      if (cfg_write) begin
        if (cfg_index[0]) offset_q[cfg_index[2:1]] = cfg_data;
        else gain_q[cfg_index[2:1]] = cfg_data;
      end
    end
    pending = expected_indices.size();
  end

endmodule

`default_nettype wire

@@ tb/tb_reflectance_normalized_index_pixel.sv @@
// ----------------------------------------------------------------------------
// tb_reflectance_normalized_index_pixel
// Drives pixels through the normalized difference index unit under several
// gain and offset settings, with random gaps and output stalls; a checker
// beside the block predicts and compares every index item.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_reflectance_normalized_index_pixel;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        dn_band3, dn_band4, dn_band5, dn_band7;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] vegetation_index, tillage_index;
  logic               vegetation_invalid, tillage_invalid;
  int                 fails;
  int                 pending;
  bit                 busy_stretch;

  reflectance_normalized_index_pixel DUT (.*);

  rndi_index_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up after a generous time
  initial begin
    #6000000;
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, a few long ones, none during busy stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_stretch || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sink side: random stalls
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (pick_gap() != 0);
  end

  task automatic write_reg(rndi_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_pixel(logic [15:0] d3, logic [15:0] d4, logic [15:0] d5,
                            logic [15:0] d7);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    dn_band3 <= d3;
    dn_band4 <= d4;
    dn_band5 <= d5;
    dn_band7 <= d7;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_dn();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r == 2) return 32'($urandom_range(0, 255)) - 32'd128;
    return $urandom;
  endfunction

  // Load one setting; some are chosen so that denominators cancel
  task automatic configure(int phase);
    logic [31:0] g3, o3, g4, o4, g5, o5, g7, o7;
    g3 = pick_word(); o3 = pick_word(); g4 = pick_word(); o4 = pick_word();
    g5 = pick_word(); o5 = pick_word(); g7 = pick_word(); o7 = pick_word();
    case (phase % 6)
      0: begin
        {g3, o3, g4, o4} = {4{32'h7FFF_FFFF}};
        {g5, o5, g7, o7} = {4{32'h8000_0000}};
      end
      1: begin
        g3 = 32'h0400_0000; g4 = 32'h0400_0000; o3 = 32'd0; o4 = 32'd0;
        g5 = 32'h0100_0000; g7 = 32'h0200_0000; o5 = 32'd0; o7 = 32'd0;
      end
      // opposite gains and near-opposite offsets: tiny denominators
      2: begin
        g4 = -g3; o4 = -o3 + $urandom_range(0, 3);
        g7 = -g5; o7 = -o5 + $urandom_range(0, 3);
      end
      3: begin
        o4 = -o3; g4 = g3;
        o7 = -o5; g7 = g5;
      end
      default: ;
    endcase
    write_reg(rndi_pkg::REG_GAIN_B3, g3);
    write_reg(rndi_pkg::REG_OFFSET_B3, o3);
    write_reg(rndi_pkg::REG_GAIN_B4, g4);
    write_reg(rndi_pkg::REG_OFFSET_B4, o4);
    write_reg(rndi_pkg::REG_GAIN_B5, g5);
    write_reg(rndi_pkg::REG_OFFSET_B5, o5);
    write_reg(rndi_pkg::REG_GAIN_B7, g7);
    write_reg(rndi_pkg::REG_OFFSET_B7, o7);
  endtask

  // Let the pipeline drain fully before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    logic [15:0] d3, d4, d5, d7;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    dn_band3 = '0; dn_band4 = '0; dn_band5 = '0; dn_band7 = '0;
    busy_stretch = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: every denominator is zero
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      configure(phase);
      busy_stretch = (phase % 4 == 3);
      // edge samples first, then random pixels
      send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      for (int n = 0; n < 80; n++) begin
        d3 = pick_dn(); d4 = pick_dn(); d5 = pick_dn(); d7 = pick_dn();
        if ($urandom_range(0, 3) == 0) begin
          d4 = d3;
          d7 = d5;
        end
        send_pixel(d3, d4, d5, d7);
      end
      busy_stretch = 1'b0;
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
